>>> hw/rtl/boolean_parenthesization_counter_top_defines.svh
// Assertion macros shared by the boolean parenthesization counter RTL.
`ifndef BOOLEAN_PARENTHESIZATION_COUNTER_TOP_DEFINES_SVH
`define BOOLEAN_PARENTHESIZATION_COUNTER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication that must hold at every clock edge outside reset.
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/bpc_pkg.sv
// Shared types, constants and modular helpers of the parenthesization counter.
package bpc_pkg;

  localparam logic [29:0] MODULUS = 30'd1000000007;
  // 2^30 mod MODULUS, the Montgomery form of one.
  localparam logic [29:0] R_MOD   = 30'd73741817;

  localparam logic [7:0] SYM_TRUE  = 8'h54;
  localparam logic [7:0] SYM_FALSE = 8'h46;
  localparam logic [7:0] SYM_OR    = 8'h7C;
  localparam logic [7:0] SYM_AND   = 8'h26;
  localparam logic [7:0] SYM_XOR   = 8'h5E;

  typedef logic [29:0] val_t;

  // Negated inverse of the modulus mod 2^30, by Newton iteration.
  function automatic logic [29:0] calc_pprime();
    logic [63:0] pw;
    logic [63:0] x;
    pw = 64'(MODULUS);
    x  = pw;
    for (int it = 0; it < 5; it++) begin
      x = x * (64'd2 - pw * x);
    end
    x = 64'd0 - x;
    return x[29:0];
  endfunction

  localparam logic [29:0] PPRIME = calc_pprime();

  function automatic val_t add_mod(val_t a, val_t b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[29:0];
  endfunction

  function automatic val_t sub_mod(val_t a, val_t b);
    logic [30:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    end
    return s[29:0];
  endfunction

  typedef enum logic [1:0] {
    TAG_P1,
    TAG_P2,
    TAG_P3,
    TAG_FIN
  } tag_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_SPAN_CHK,
    ST_SPAN_START,
    ST_SPLIT_CHK,
    ST_SPLIT_RD,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_WAIT_P3,
    ST_ACC1,
    ST_ACC2,
    ST_ACC3,
    ST_SPAN_WR,
    ST_FIN_RD,
    ST_FIN_MUL,
    ST_WAIT_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic init_start;
    logic diag_wr;
    logic span_start;
    logic mul1;
    logic mul2;
    logic mul3;
    logic fin_mul;
    logic acc1;
    logic acc2;
    logic acc3;
    logic span_wr;
    logic fin_setup;
    logic clear_expr;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic split_more;
    logic len_ok;
    logic p3_done;
    logic fin_done;
  } status_t;

endpackage

>>> hw/rtl/bpc_in_if.sv
// Input channel: one expression character per transaction.
interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

>>> hw/rtl/bpc_out_if.sv
// Output channel: one count result per transaction.
interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] true_ways;
  logic        overflow;

  modport source (output valid, output true_ways, output overflow, input ready);
  modport sink (input valid, input true_ways, input overflow, output ready);
endinterface

>>> hw/rtl/bpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bpc_mont_mul.sv
// Four-stage pipelined Montgomery multiplier modulo 1000000007 with R = 2^30.
module bpc_mont_mul import bpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  tag_e in_tag_i,
  input  val_t a_i,
  input  val_t b_i,
  output logic out_valid_o,
  output tag_e out_tag_o,
  output val_t res_o
);

  logic [3:0]  valid_q;
  tag_e        tag_q [4];
  logic [59:0] prod1_q;
  logic [59:0] prod2_q;
  logic [29:0] m2_q;
  logic [30:0] s3_q;
  val_t        res_q;

  logic [59:0] prod1_d;
  logic [59:0] mlo;
  logic [59:0] mp;
  logic [60:0] sum3;

  assign prod1_d = {30'd0, a_i} * {30'd0, b_i};
  assign mlo     = {30'd0, prod1_q[29:0]} * {30'd0, PPRIME};
  assign mp      = {30'd0, m2_q} * {30'd0, MODULUS};
  assign sum3    = {1'b0, prod2_q} + {1'b0, mp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= in_tag_i;
    tag_q[1] <= tag_q[0];
    tag_q[2] <= tag_q[1];
    tag_q[3] <= tag_q[2];
    prod1_q  <= prod1_d;
    m2_q     <= mlo[29:0];
    prod2_q  <= prod1_q;
    s3_q     <= sum3[60:30];
    if (s3_q >= {1'b0, MODULUS}) begin
      res_q <= 30'(s3_q - {1'b0, MODULUS});
    end else begin
      res_q <= s3_q[29:0];
    end
  end

  assign out_valid_o = valid_q[3];
  assign out_tag_o   = tag_q[3];
  assign res_o       = res_q;

endmodule

>>> hw/rtl/bpc_datapath.sv
// Datapath: symbol store, span tables, index counters and modular accumulators.
module bpc_datapath import bpc_pkg::*; #(
  parameter int unsigned MaxSymbols = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [7:0]  symbol_i,
  output logic [29:0] true_ways_o,
  output logic        overflow_o
);

`include "boolean_parenthesization_counter_top_defines.svh"

  localparam int unsigned IW     = $clog2(MaxSymbols);
  localparam int unsigned CW     = $clog2(MaxSymbols + 1);
  localparam int unsigned LW     = $clog2(MaxSymbols + 2);
  localparam int unsigned AW     = 2 * IW;
  localparam int unsigned TDepth = 1 << AW;

  logic [CW-1:0] count_q;
  logic          drop_q;
  logic [IW-1:0] i_q, j_q, k_q;
  logic [LW-1:0] len_q;
  val_t          t_q, f_q, p1_q, p2_q, p3_q, s12_q, dt_q, df_q, sl_q, sr_q, res_q;
  logic [7:0]    op_q;

  logic          has_room;
  logic [IW-1:0] n_last, km1, kp1;
  logic [LW:0]   i_plus_len;
  logic [7:0]    sym_rdata;
  logic [59:0]   left_rdata, right_rdata;
  val_t          lt, lf, rt, rf;
  logic          tab_we;
  logic [AW-1:0] tab_waddr;
  logic [59:0]   tab_wdata;
  val_t          dg_t, dg_f;
  logic          mul_in_valid;
  tag_e          mul_in_tag;
  val_t          mul_a, mul_b;
  logic          mul_valid;
  tag_e          mul_tag;
  val_t          mul_res;
  val_t          dt_d, df_d;

  assign has_room   = count_q < CW'(MaxSymbols);
  assign n_last     = IW'(count_q - CW'(1));
  assign km1        = k_q - IW'(1);
  assign kp1        = k_q + IW'(1);
  assign i_plus_len = (LW + 1)'(i_q) + (LW + 1)'(len_q);

  assign lt = left_rdata[59:30];
  assign lf = left_rdata[29:0];
  assign rt = right_rdata[59:30];
  assign rf = right_rdata[29:0];

  assign dg_t = (sym_rdata == SYM_TRUE) ? R_MOD : '0;
  assign dg_f = (sym_rdata == SYM_FALSE) ? R_MOD : '0;

  assign tab_we    = cmd_i.diag_wr | cmd_i.span_wr;
  assign tab_waddr = cmd_i.diag_wr ? {k_q, k_q} : {i_q, j_q};
  assign tab_wdata = cmd_i.diag_wr ? {dg_t, dg_f} : {t_q, f_q};

  bpc_ram #(.Width(8), .Depth(MaxSymbols)) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load & has_room),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (k_q),
    .rdata_o (sym_rdata)
  );

  // Two copies of the span tables so the left and right operands read together.
  bpc_ram #(.Width(60), .Depth(TDepth)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i ({i_q, km1}),
    .rdata_o (left_rdata)
  );

  bpc_ram #(.Width(60), .Depth(TDepth)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i ({kp1, j_q}),
    .rdata_o (right_rdata)
  );

  always_comb begin
    mul_a      = lt;
    mul_b      = rt;
    mul_in_tag = TAG_P1;
    if (cmd_i.mul2) begin
      mul_a      = lf;
      mul_b      = rf;
      mul_in_tag = TAG_P2;
    end else if (cmd_i.mul3) begin
      mul_a      = sl_q;
      mul_b      = sr_q;
      mul_in_tag = TAG_P3;
    end else if (cmd_i.fin_mul) begin
      mul_a      = rt;
      mul_b      = val_t'(1);
      mul_in_tag = TAG_FIN;
    end
  end

  assign mul_in_valid = cmd_i.mul1 | cmd_i.mul2 | cmd_i.mul3 | cmd_i.fin_mul;

  bpc_mont_mul u_mont_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_in_valid),
    .in_tag_i    (mul_in_tag),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .out_valid_o (mul_valid),
    .out_tag_o   (mul_tag),
    .res_o       (mul_res)
  );

  // Per-split contribution; the total (lt+lf)(rt+rf) stands in for sums of products.
  always_comb begin
    case (op_q)
      SYM_OR: begin
        dt_d = sub_mod(p3_q, p2_q);
        df_d = p2_q;
      end
      SYM_AND: begin
        dt_d = p1_q;
        df_d = sub_mod(p3_q, p1_q);
      end
      SYM_XOR: begin
        dt_d = sub_mod(p3_q, s12_q);
        df_d = s12_q;
      end
      default: begin
        dt_d = '0;
        df_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      len_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        if (has_room) begin
          count_q <= count_q + CW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.clear_expr) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end
      if (cmd_i.init_start) begin
        i_q   <= '0;
        k_q   <= '0;
        len_q <= LW'(2);
      end
      if (cmd_i.diag_wr || cmd_i.acc3) begin
        k_q <= kp1;
      end
      if (cmd_i.span_start) begin
        j_q <= IW'(i_plus_len - (LW + 1)'(1));
        k_q <= i_q + IW'(1);
      end
      if (cmd_i.span_wr) begin
        if (i_plus_len < (LW + 1)'(count_q)) begin
          i_q <= i_q + IW'(1);
        end else begin
          i_q   <= '0;
          len_q <= len_q + LW'(1);
        end
      end
      if (cmd_i.fin_setup) begin
        k_q <= '1;
        j_q <= n_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.span_start) begin
      t_q <= '0;
      f_q <= '0;
    end
    if (cmd_i.mul1) begin
      sl_q <= add_mod(lt, lf);
      sr_q <= add_mod(rt, rf);
      op_q <= sym_rdata;
    end
    if (mul_valid) begin
      case (mul_tag)
        TAG_P1:  p1_q  <= mul_res;
        TAG_P2:  p2_q  <= mul_res;
        TAG_P3:  p3_q  <= mul_res;
        TAG_FIN: res_q <= mul_res;
        default: res_q <= mul_res;
      endcase
    end
    if (cmd_i.acc1) begin
      s12_q <= add_mod(p1_q, p2_q);
    end
    if (cmd_i.acc2) begin
      dt_q <= dt_d;
      df_q <= df_d;
    end
    if (cmd_i.acc3) begin
      t_q <= add_mod(t_q, dt_q);
      f_q <= add_mod(f_q, df_q);
    end
  end

  assign status_o.init_last  = (k_q == n_last);
  assign status_o.split_more = (k_q < j_q);
  assign status_o.len_ok     = ({1'b0, len_q} <= (LW + 1)'(count_q));
  assign status_o.p3_done    = mul_valid && (mul_tag == TAG_P3);
  assign status_o.fin_done   = mul_valid && (mul_tag == TAG_FIN);

  assign true_ways_o = res_q;
  assign overflow_o  = drop_q;

  `BPC_ASSERT(a_count_range, count_q <= CW'(MaxSymbols), "symbol count beyond capacity")
  `BPC_ASSERT_IMP(a_p3_latency, cmd_i.mul3, ##4 (mul_valid && (mul_tag == TAG_P3)), "total product late")

endmodule

>>> hw/rtl/bpc_ctrl.sv
// Controller: sequences loading, table fill, split accumulation and result hand-off.
module bpc_ctrl import bpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

`include "boolean_parenthesization_counter_top_defines.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_INIT_RD;
      end
      ST_INIT_RD:    state_d = ST_INIT_WR;
      ST_INIT_WR:    state_d = status_i.init_last ? ST_SPAN_CHK : ST_INIT_RD;
      ST_SPAN_CHK:   state_d = status_i.len_ok ? ST_SPAN_START : ST_FIN_RD;
      ST_SPAN_START: state_d = ST_SPLIT_CHK;
      ST_SPLIT_CHK:  state_d = status_i.split_more ? ST_SPLIT_RD : ST_SPAN_WR;
      ST_SPLIT_RD:   state_d = ST_MUL1;
      ST_MUL1:       state_d = ST_MUL2;
      ST_MUL2:       state_d = ST_MUL3;
      ST_MUL3:       state_d = ST_WAIT_P3;
      ST_WAIT_P3: begin
        if (status_i.p3_done) state_d = ST_ACC1;
      end
      ST_ACC1:       state_d = ST_ACC2;
      ST_ACC2:       state_d = ST_ACC3;
      ST_ACC3:       state_d = ST_SPLIT_CHK;
      ST_SPAN_WR:    state_d = ST_SPAN_CHK;
      ST_FIN_RD:     state_d = ST_FIN_MUL;
      ST_FIN_MUL:    state_d = ST_WAIT_FIN;
      ST_WAIT_FIN: begin
        if (status_i.fin_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load       = in_valid_i;
        cmd_o.init_start = in_valid_i & in_last_i;
      end
      ST_INIT_WR:    cmd_o.diag_wr    = 1'b1;
      ST_SPAN_CHK:   cmd_o.fin_setup  = ~status_i.len_ok;
      ST_SPAN_START: cmd_o.span_start = 1'b1;
      ST_MUL1:       cmd_o.mul1       = 1'b1;
      ST_MUL2:       cmd_o.mul2       = 1'b1;
      ST_MUL3:       cmd_o.mul3       = 1'b1;
      ST_ACC1:       cmd_o.acc1       = 1'b1;
      ST_ACC2:       cmd_o.acc2       = 1'b1;
      ST_ACC3:       cmd_o.acc3       = 1'b1;
      ST_SPAN_WR:    cmd_o.span_wr    = 1'b1;
      ST_FIN_MUL:    cmd_o.fin_mul    = 1'b1;
      ST_OUT: begin
        out_valid_o      = 1'b1;
        cmd_o.clear_expr = out_ready_i;
      end
      default: cmd_o = '0;
    endcase
  end

  `BPC_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input taken while result pending")
  `BPC_ASSERT(a_one_issue, $onehot0({cmd_o.mul1, cmd_o.mul2, cmd_o.mul3, cmd_o.fin_mul}), "two multiplier issues")
  `BPC_ASSERT_IMP(a_out_src, $rose(out_valid_o), $past(state_q == ST_WAIT_FIN), "result raised without final product")

endmodule

>>> hw/rtl/boolean_parenthesization_counter_top.sv
// Top level of the boolean parenthesization counter.
//
//   Channel   Direction  Payload                         Transaction
//   in_i      sink       symbol[7:0], last               one expression character
//   out_o     source     true_ways[29:0], overflow       one count per expression
//
// in_i stays ready throughout loading. After the transaction that carries last,
// the block seeds the diagonal once per stored character, then works through
// the spans in order of length, one split point at a time, and finally converts
// the whole-expression true count before out_o goes valid. The single shared
// Montgomery multiplier computes every product.
// Reset is asynchronous and active low; it clears the controller, counters and
// the dropped flag. The span tables need no clearing, since every entry is
// written before it is read. in_i is held off while a count is computed and
// while a result waits on out_o.
module boolean_parenthesization_counter_top import bpc_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  bpc_in_if.sink   in_i,
  bpc_out_if.source out_o
);

  // Commands flow from the controller into the datapath; status flows back.
  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  bpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the characters, both span tables in Montgomery form,
  // and converts the whole-expression true count back on the way out.
  bpc_datapath #(.MaxSymbols(MAX_SYMBOLS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .symbol_i    (in_i.symbol),
    .true_ways_o (out_o.true_ways),
    .overflow_o  (out_o.overflow)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
